@@ src/port_range_allocator_assert.svh @@
// ---------------------------------------------------------------------------
// port range allocator assertion macros
// concurrent checks clocked on clk, disabled while rst_n is low
// ---------------------------------------------------------------------------
`ifndef PORT_RANGE_ALLOCATOR_ASSERT_SVH
`define PORT_RANGE_ALLOCATOR_ASSERT_SVH
`ifndef SYNTH
`define PRA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define PRA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PRA_ASSERT_IMP(lbl, ante, cons, msg)
`define PRA_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

@@ src/pra_pkg.sv @@
// ---------------------------------------------------------------------------
// pra_pkg
// shared widths, constants, operation codes and result type
// ---------------------------------------------------------------------------
package pra_pkg;

  localparam int PORT_SLOTS_DEF  = 1024;
  localparam int MAX_REQUEST_DEF = 16;

  localparam int PORT_W     = 16;
  localparam int SLOT_W     = 4;
  localparam int OP_W       = 2;
  localparam int REQ_W      = 5;
  localparam int CNT_CFG_W  = 11;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [PORT_W-1:0]    DEFAULT_START = 16'd16000;
  localparam logic [CNT_CFG_W-1:0] DEFAULT_COUNT = 11'd1000;

  localparam logic [OP_W-1:0] OP_SCATTER = 2'd0;
  localparam logic [OP_W-1:0] OP_CONTIG  = 2'd1;
  localparam logic [OP_W-1:0] OP_FREE    = 2'd2;
  localparam logic [OP_W-1:0] OP_UNUSED  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_START = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT = 1'd1;

  typedef struct packed {
    logic [PORT_W-1:0] port;
    logic [SLOT_W-1:0] slot;
    logic              success;
    logic              last;
  } result_t;

endpackage

@@ src/pra_bitmap_mem.sv @@
// ---------------------------------------------------------------------------
// pra_bitmap_mem
// one taken bit per port, one write and one registered read per cycle
// ---------------------------------------------------------------------------
module pra_bitmap_mem #(
  parameter int DEPTH = pra_pkg::PORT_SLOTS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic                     wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic                     rdata
);

  logic mem [DEPTH];
  logic rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ src/pra_out_reg.sv @@
// ---------------------------------------------------------------------------
// pra_out_reg
// result register between the sequencer and the output channel
// ---------------------------------------------------------------------------
module pra_out_reg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          res_valid,
  input  pra_pkg::result_t              res_data,
  output logic                          res_ready,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pra_pkg::PORT_W-1:0]    out_granted_port,
  output logic [pra_pkg::SLOT_W-1:0]    out_slot_index,
  output logic                          out_success,
  output logic                          out_last
);
  import pra_pkg::*;

  logic    out_valid_r;
  logic    out_valid_nxt;
  result_t data_r;

  // take a new item when empty or when the held one leaves this cycle
  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_ready) begin
      out_valid_nxt = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      data_r <= res_data;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_granted_port = data_r.port;
  assign out_slot_index   = data_r.slot;
  assign out_success      = data_r.success;
  assign out_last         = data_r.last;

endmodule

@@ src/port_range_allocator.sv @@
// ---------------------------------------------------------------------------
// port_range_allocator
// first-fit port allocator over a configured port range
// ---------------------------------------------------------------------------
// The taken bits live in a single-port-per-direction memory of PORT_SLOTS
// bits, scanned one port per cycle. After reset and after every write of
// start_port or port_count the block runs a clearing pass over all
// PORT_SLOTS bits with in_ready low. A free item (and an unused operation or
// a bad request_count) is answered with a single status result. A
// scattered or contiguous allocation scans from the bottom of the range
// until it has enough ports, at one memory read per cycle with the read data
// registered, then delivers one result per cycle while the output register
// takes them. The scan through the memory read port is the long part of an
// allocation. One item is worked on at a time; the next is accepted while
// the last result still waits in the output register.
// ---------------------------------------------------------------------------
`include "port_range_allocator_assert.svh"

module port_range_allocator #(
  parameter int PORT_SLOTS  = pra_pkg::PORT_SLOTS_DEF,
  parameter int MAX_REQUEST = pra_pkg::MAX_REQUEST_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration write port
  input  logic                            cfg_we,
  input  logic [pra_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pra_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  // request channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [pra_pkg::OP_W-1:0]        in_operation,
  input  logic [pra_pkg::REQ_W-1:0]       in_request_count,
  input  logic [pra_pkg::PORT_W-1:0]      in_port_number,
  // result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [pra_pkg::PORT_W-1:0]      out_granted_port,
  output logic [pra_pkg::SLOT_W-1:0]      out_slot_index,
  output logic                            out_success,
  output logic                            out_last
);
  import pra_pkg::*;

  localparam int AW    = $clog2(PORT_SLOTS);
  localparam int CNT_W = $clog2(PORT_SLOTS + 1);
  localparam int KW    = $clog2(MAX_REQUEST + 1);
  localparam int FW    = (MAX_REQUEST > 1) ? $clog2(MAX_REQUEST) : 1;

  // sequencer states
  localparam logic [2:0] ST_CLEAR  = 3'd0;  // zeroing sweep of the bitmap
  localparam logic [2:0] ST_IDLE   = 3'd1;  // waiting for an item
  localparam logic [2:0] ST_SCAN_S = 3'd2;  // scattered scan
  localparam logic [2:0] ST_SCAN_C = 3'd3;  // contiguous run search
  localparam logic [2:0] ST_EMIT   = 3'd4;  // one result per granted port
  localparam logic [2:0] ST_SINGLE = 3'd5;  // lone status result

  logic [2:0]            state_r, state_nxt;
  logic [PORT_W-1:0]     start_r;
  logic [CNT_CFG_W-1:0]  count_r;

  // effective range, re-registered every cycle from the range registers
  logic [PORT_W-1:0]     eff_base, eff_base_r;
  logic [CNT_W-1:0]      eff_cnt, eff_cnt_r;

  logic [REQ_W-1:0]      n_r, n_nxt;
  logic [CNT_W-1:0]      clr_idx_r, clr_idx_nxt;
  logic [CNT_W-1:0]      issue_idx_r, issue_idx_nxt;
  logic                  pend_valid_r, pend_valid_nxt;
  logic [AW-1:0]         pend_idx_r, pend_idx_nxt;
  logic [KW-1:0]         k_r, k_nxt;
  logic [REQ_W-1:0]      run_r, run_nxt;
  logic [CNT_W-1:0]      s_r, s_nxt;
  logic [KW-1:0]         emit_idx_r, emit_idx_nxt;
  logic [KW-1:0]         emit_tot_r, emit_tot_nxt;
  logic                  emit_contig_r, emit_contig_nxt;
  logic                  single_ok_r, single_ok_nxt;

  // ports found by a scattered scan, lowest first
  logic [PORT_W-1:0]     found_r [MAX_REQUEST];
  logic                  found_we;
  logic [FW-1:0]         found_widx;
  logic [PORT_W-1:0]     found_wdata;

  // bitmap memory port
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic                  mem_wdata;
  logic [AW-1:0]         mem_raddr;
  logic                  mem_rdata;

  // result handoff to the output register
  logic                  res_valid;
  logic                  res_ready;
  result_t               res_data;

  // free range check
  logic [PORT_W:0]       free_off;
  logic                  free_in_range;
  logic                  req_bad;

  // ------------------------------------------------------------------
  // effective base and count; count 0 selects the default range, then
  // the count is capped to the bitmap and to the top of the port space
  // ------------------------------------------------------------------
  always_comb begin
    logic [PORT_W:0] cnt_w;
    logic [PORT_W:0] lim_w;
    eff_base = (count_r == '0) ? DEFAULT_START : start_r;
    cnt_w    = (count_r == '0) ? (PORT_W+1)'(DEFAULT_COUNT) : (PORT_W+1)'(count_r);
    if (cnt_w > (PORT_W+1)'(PORT_SLOTS)) begin
      cnt_w = (PORT_W+1)'(PORT_SLOTS);
    end
    lim_w = (PORT_W+1)'(17'h10000) - {1'b0, eff_base};
    if (cnt_w > lim_w) begin
      cnt_w = lim_w;
    end
    eff_cnt = cnt_w[CNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    eff_base_r <= eff_base;
    eff_cnt_r  <= eff_cnt;
  end

  assign free_off      = {1'b0, in_port_number} - {1'b0, eff_base_r};
  assign free_in_range = (in_port_number >= eff_base_r) &&
                         (free_off < (PORT_W+1)'(eff_cnt_r));
  assign req_bad       = (in_request_count == '0) ||
                         (int'(in_request_count) > MAX_REQUEST);

  assign in_ready  = (state_r == ST_IDLE);
  assign mem_raddr = issue_idx_r[AW-1:0];

  // ------------------------------------------------------------------
  // sequencer
  // ------------------------------------------------------------------
  always_comb begin
    logic            hit;
    logic [KW-1:0]   k_inc;
    logic [REQ_W-1:0] run_inc;
    logic            exhausted;
    logic            can_issue;
    logic [KW-1:0]   j;
    logic [7:0]      slot_w;
    logic [PORT_W:0] cport_w;
    logic [CNT_W:0]  caddr_w;
    logic [PORT_W:0] s_w;
    logic [PORT_W:0] fport_w;

    state_nxt       = state_r;
    n_nxt           = n_r;
    clr_idx_nxt     = clr_idx_r;
    issue_idx_nxt   = issue_idx_r;
    pend_valid_nxt  = pend_valid_r;
    pend_idx_nxt    = pend_idx_r;
    k_nxt           = k_r;
    run_nxt         = run_r;
    s_nxt           = s_r;
    emit_idx_nxt    = emit_idx_r;
    emit_tot_nxt    = emit_tot_r;
    emit_contig_nxt = emit_contig_r;
    single_ok_nxt   = single_ok_r;

    found_we    = 1'b0;
    found_widx  = k_r[FW-1:0];
    fport_w     = {1'b0, eff_base_r} + (PORT_W+1)'(pend_idx_r);
    found_wdata = fport_w[PORT_W-1:0];

    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = 1'b0;

    res_valid = 1'b0;
    res_data  = '0;

    hit       = pend_valid_r && !mem_rdata;
    k_inc     = k_r + 1'b1;
    run_inc   = run_r + 1'b1;
    exhausted = !pend_valid_r && (issue_idx_r >= eff_cnt_r);
    can_issue = issue_idx_r < eff_cnt_r;

    j       = emit_tot_r - 1'b1 - emit_idx_r;
    slot_w  = 8'(n_r) - 8'd1 - 8'(j);
    cport_w = {1'b0, eff_base_r} + (PORT_W+1)'(s_r) + (PORT_W+1)'(emit_idx_r);
    caddr_w = (CNT_W+1)'(s_r) + (CNT_W+1)'(emit_idx_r);
    s_w     = (PORT_W+1)'(pend_idx_r) + (PORT_W+1)'(1) - (PORT_W+1)'(n_r);

    unique case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx_r[AW-1:0];
        mem_wdata = 1'b0;
        if (clr_idx_r == CNT_W'(PORT_SLOTS - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_idx_nxt = clr_idx_r + 1'b1;
        end
      end

      ST_IDLE: begin
        if (in_valid) begin
          n_nxt          = in_request_count;
          k_nxt          = '0;
          run_nxt        = '0;
          issue_idx_nxt  = '0;
          pend_valid_nxt = 1'b0;
          emit_idx_nxt   = '0;
          priority if (in_operation == OP_FREE) begin
            // release one port; outside the range nothing changes
            if (free_in_range) begin
              mem_we    = 1'b1;
              mem_waddr = free_off[AW-1:0];
              mem_wdata = 1'b0;
            end
            single_ok_nxt = free_in_range;
            state_nxt     = ST_SINGLE;
          end else if (in_operation == OP_UNUSED || req_bad) begin
            single_ok_nxt = 1'b0;
            state_nxt     = ST_SINGLE;
          end else if (in_operation == OP_SCATTER) begin
            state_nxt = ST_SCAN_S;
          end else begin
            state_nxt = ST_SCAN_C;
          end
        end
      end

      ST_SCAN_S: begin
        if (hit) begin
          // claim the free port right away
          mem_we    = 1'b1;
          mem_waddr = pend_idx_r;
          mem_wdata = 1'b1;
          found_we  = 1'b1;
          k_nxt     = k_inc;
        end
        if (hit && (k_inc == KW'(n_r))) begin
          state_nxt       = ST_EMIT;
          emit_tot_nxt    = k_inc;
          emit_contig_nxt = 1'b0;
          pend_valid_nxt  = 1'b0;
        end else if (exhausted) begin
          // shortfall: whatever was found stays taken
          if (k_r == '0) begin
            single_ok_nxt = 1'b0;
            state_nxt     = ST_SINGLE;
          end else begin
            state_nxt       = ST_EMIT;
            emit_tot_nxt    = k_r;
            emit_contig_nxt = 1'b0;
          end
        end else begin
          pend_valid_nxt = can_issue;
          pend_idx_nxt   = issue_idx_r[AW-1:0];
          if (can_issue) begin
            issue_idx_nxt = issue_idx_r + 1'b1;
          end
        end
      end

      ST_SCAN_C: begin
        if (pend_valid_r) begin
          run_nxt = mem_rdata ? '0 : run_inc;
        end
        if (hit && (run_inc >= n_r)) begin
          // run ends at the port just read; bits are set while emitting
          s_nxt           = s_w[CNT_W-1:0];
          state_nxt       = ST_EMIT;
          emit_tot_nxt    = KW'(n_r);
          emit_contig_nxt = 1'b1;
          pend_valid_nxt  = 1'b0;
        end else if (exhausted) begin
          single_ok_nxt = 1'b0;
          state_nxt     = ST_SINGLE;
        end else begin
          pend_valid_nxt = can_issue;
          pend_idx_nxt   = issue_idx_r[AW-1:0];
          if (can_issue) begin
            issue_idx_nxt = issue_idx_r + 1'b1;
          end
        end
      end

      ST_EMIT: begin
        res_valid = 1'b1;
        if (emit_contig_r) begin
          res_data.port    = cport_w[PORT_W-1:0];
          res_data.slot    = SLOT_W'(emit_idx_r);
          res_data.success = 1'b1;
        end else begin
          // highest found port first, it holds the lowest slot
          res_data.port    = found_r[j[FW-1:0]];
          res_data.slot    = slot_w[SLOT_W-1:0];
          res_data.success = (emit_tot_r == KW'(n_r));
        end
        res_data.last = (emit_idx_r == emit_tot_r - 1'b1);
        if (res_ready) begin
          if (emit_contig_r) begin
            mem_we    = 1'b1;
            mem_waddr = caddr_w[AW-1:0];
            mem_wdata = 1'b1;
          end
          emit_idx_nxt = emit_idx_r + 1'b1;
          if (res_data.last) begin
            state_nxt = ST_IDLE;
          end
        end
      end

      ST_SINGLE: begin
        res_valid        = 1'b1;
        res_data.success = single_ok_r;
        res_data.last    = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt   = ST_CLEAR;
        clr_idx_nxt = '0;
      end
    endcase

    // a range write wipes the bitmap and restarts the sweep
    if (cfg_we) begin
      state_nxt      = ST_CLEAR;
      clr_idx_nxt    = '0;
      pend_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_idx_r    <= '0;
      pend_valid_r <= 1'b0;
      start_r      <= DEFAULT_START;
      count_r      <= DEFAULT_COUNT;
    end else begin
      state_r      <= state_nxt;
      clr_idx_r    <= clr_idx_nxt;
      pend_valid_r <= pend_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_START: start_r <= cfg_wdata;
          REG_COUNT: count_r <= cfg_wdata[CNT_CFG_W-1:0];
          default:   start_r <= start_r;
        endcase
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    n_r           <= n_nxt;
    issue_idx_r   <= issue_idx_nxt;
    pend_idx_r    <= pend_idx_nxt;
    k_r           <= k_nxt;
    run_r         <= run_nxt;
    s_r           <= s_nxt;
    emit_idx_r    <= emit_idx_nxt;
    emit_tot_r    <= emit_tot_nxt;
    emit_contig_r <= emit_contig_nxt;
    single_ok_r   <= single_ok_nxt;
    if (found_we) begin
      found_r[found_widx] <= found_wdata;
    end
  end

  pra_bitmap_mem #(
    .DEPTH (PORT_SLOTS)
  ) u_bitmap (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  pra_out_reg u_out (
    .clk              (clk),
    .rst_n            (rst_n),
    .res_valid        (res_valid),
    .res_data         (res_data),
    .res_ready        (res_ready),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_granted_port (out_granted_port),
    .out_slot_index   (out_slot_index),
    .out_success      (out_success),
    .out_last         (out_last)
  );

  // ------------------------------------------------------------------
  // checks
  // ------------------------------------------------------------------
  `PRA_ASSERT_IMP(a_scan_below_request, state_r == ST_SCAN_S, k_r < KW'(n_r), "scan overran")
  `PRA_ASSERT_IMP(a_pend_in_range, pend_valid_r, CNT_W'(pend_idx_r) < eff_cnt_r, "bad read")
  `PRA_ASSERT_IMP(a_emit_in_bounds, state_r == ST_EMIT, emit_idx_r < emit_tot_r, "emit overran")
  `PRA_ASSERT_NXT(a_last_to_idle, res_ready && res_data.last, state_r == ST_IDLE, "missed idle")

endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// checks the port range allocator: requests go in over a valid/ready channel,
// every result item is matched field by field against a cycle-free model of
// the taken-port bitmap, across default, tiny, top-of-space and saturated
// ranges, with random gaps on both channels and one long output stall
// ----------------------------------------------------------------------------

class port_grant_scoreboard;
  logic [pra_pkg::PORT_W-1:0]    start_reg;
  logic [pra_pkg::CNT_CFG_W-1:0] count_reg;
  bit                            taken [pra_pkg::PORT_SLOTS_DEF];
  pra_pkg::result_t              due_results [$];
  int unsigned mismatches;
  int unsigned requests;
  int unsigned results;
  int unsigned shortfalls;
  int unsigned contig_misses;
  int unsigned frees_hit;

  function new();
    start_reg     = pra_pkg::DEFAULT_START;
    count_reg     = pra_pkg::DEFAULT_COUNT;
    mismatches    = 0;
    requests      = 0;
    results       = 0;
    shortfalls    = 0;
    contig_misses = 0;
    frees_hit     = 0;
    clear_bitmap();
  endfunction

  function void clear_bitmap();
    foreach (taken[i]) taken[i] = 1'b0;
  endfunction

  function void write_reg(logic [pra_pkg::CFG_IDX_W-1:0] idx,
                          logic [pra_pkg::CFG_DATA_W-1:0] data);
    if (idx == pra_pkg::REG_START) start_reg = data;
    else count_reg = data[pra_pkg::CNT_CFG_W-1:0];
    clear_bitmap();
  endfunction

  function int range_base();
    return (count_reg == '0) ? int'(pra_pkg::DEFAULT_START) : int'(start_reg);
  endfunction

  // saturate to the bitmap depth and to the top of the port space
  function int range_size();
    int span;
    int base;
    base = range_base();
    span = (count_reg == '0) ? int'(pra_pkg::DEFAULT_COUNT) : int'(count_reg);
    if (span > pra_pkg::PORT_SLOTS_DEF) span = pra_pkg::PORT_SLOTS_DEF;
    if (span > 65536 - base) span = 65536 - base;
    return span;
  endfunction

  function void queue_result(int port, int slot, bit ok, bit fin);
    pra_pkg::result_t r;
    r.port    = port[15:0];
    r.slot    = slot[3:0];
    r.success = ok;
    r.last    = fin;
    due_results.insert(due_results.size(), r);
  endfunction

  function void note_request(logic [pra_pkg::OP_W-1:0] op,
                             logic [pra_pkg::REQ_W-1:0] want,
                             logic [pra_pkg::PORT_W-1:0] port_no);
    int base;
    int span;
    int n;
    int p;
    int k;
    int run;
    int i;
    int s;
    int found [pra_pkg::MAX_REQUEST_DEF];
    base = range_base();
    span = range_size();
    n    = int'(want);
    p    = int'(port_no);
    requests++;
    if (op == pra_pkg::OP_FREE) begin
      if (p >= base && p - base < span) begin
        taken[p - base] = 1'b0;
        frees_hit++;
        queue_result(0, 0, 1'b1, 1'b1);
      end else begin
        queue_result(0, 0, 1'b0, 1'b1);
      end
      return;
    end
    if (op == pra_pkg::OP_UNUSED || n == 0 || n > pra_pkg::MAX_REQUEST_DEF) begin
      queue_result(0, 0, 1'b0, 1'b1);
      return;
    end
    if (op == pra_pkg::OP_SCATTER) begin
      k = 0;
      for (i = 0; i < span && k < n; i++) begin
        if (!taken[i]) begin
          taken[i] = 1'b1;
          found[k] = base + i;
          k++;
        end
      end
      if (k < n) shortfalls++;
      if (k == 0) begin
        queue_result(0, 0, 1'b0, 1'b1);
        return;
      end
      // lowest port holds the highest slot; results leave in ascending slot order
      for (i = 0; i < k; i++)
        queue_result(found[k - 1 - i], n - k + i, k == n, i == k - 1);
      return;
    end
    run = 0;
    for (i = 0; i < span; i++) begin
      if (taken[i]) begin
        run = 0;
      end else begin
        run++;
        if (run >= n) break;
      end
    end
    if (i >= span) begin
      contig_misses++;
      queue_result(0, 0, 1'b0, 1'b1);
      return;
    end
    s = i + 1 - n;
    for (i = 0; i < n; i++) begin
      taken[s + i] = 1'b1;
      queue_result(base + s + i, i, 1'b1, i == n - 1);
    end
  endfunction

  task report_mismatch(string what);
    if (mismatches < 40) $display("mismatch at result %0d: %s", results, what);
    mismatches++;
  endtask

  task check_result(pra_pkg::result_t got);
    pra_pkg::result_t oldest;
    if (due_results.size() == 0) begin
      report_mismatch($sformatf("unexpected result port %0d slot %0d", got.port, got.slot));
      return;
    end
    oldest = due_results.pop_front();
    results++;
    if (got.port !== oldest.port)
      report_mismatch($sformatf("granted_port %0d, want %0d", got.port, oldest.port));
    if (got.slot !== oldest.slot)
      report_mismatch($sformatf("slot_index %0d, want %0d", got.slot, oldest.slot));
    if (got.success !== oldest.success)
      report_mismatch($sformatf("success %b, want %b", got.success, oldest.success));
    if (got.last !== oldest.last)
      report_mismatch($sformatf("last %b, want %b", got.last, oldest.last));
  endtask
endclass

module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pra_pkg::*;

  localparam int HOLD_OFF_CYCLES = 400;
  localparam int SETTLE_LIMIT    = 200000;
  localparam int TAIL_CYCLES     = 16;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_ready;
  logic [OP_W-1:0]       in_operation;
  logic [REQ_W-1:0]      in_request_count;
  logic [PORT_W-1:0]     in_port_number;
  logic                  out_valid;
  logic                  out_ready;
  logic [PORT_W-1:0]     out_granted_port;
  logic [SLOT_W-1:0]     out_slot_index;
  logic                  out_success;
  logic                  out_last;

  // steady_flow turns off random gaps on both sides for one whole phase
  bit steady_flow      = 1'b0;
  bit hold_off_request = 1'b0;
  bit hold_off_done    = 1'b0;
  int settings         = 0;

  port_grant_scoreboard sb;

  port_range_allocator u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_request_count (in_request_count),
    .in_port_number   (in_port_number),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_granted_port (out_granted_port),
    .out_slot_index   (out_slot_index),
    .out_success      (out_success),
    .out_last         (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // result side: ready changes on the falling edge, one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_request && !hold_off_done) begin
        hold_off_done = 1'b1;
        out_ready = 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end
      out_ready = steady_flow || ($urandom_range(0, 99) >= 11);
    end
  end

  // every accepted result item goes to the scoreboard
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready)
      sb.check_result(result_t'({out_granted_port, out_slot_index, out_success, out_last}));
  end

  // offer one item; called and returns just after a falling edge, valid left
  // high so a following item can go out back to back
  task automatic send_request(input logic [OP_W-1:0] op, input logic [REQ_W-1:0] want,
                              input logic [PORT_W-1:0] port);
    while (!steady_flow && $urandom_range(0, 99) < 11) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid         = 1'b1;
    in_operation     = op;
    in_request_count = want;
    in_port_number   = port;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_request(op, want, port);
    @(negedge clk);
  endtask

  // stop offering and wait until every expected result item has come back
  task automatic settle();
    int guard;
    in_valid = 1'b0;
    guard = 0;
    while (sb.due_results.size() != 0 && guard < SETTLE_LIMIT) begin
      @(negedge clk);
      guard++;
    end
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(posedge clk);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // each write wipes the bitmap; the block then clears with in_ready low
  task automatic program_range(input logic [PORT_W-1:0] first, input logic [CNT_CFG_W-1:0] span);
    settle();
    write_reg(REG_START, first);
    write_reg(REG_COUNT, CFG_DATA_W'(span));
    settings++;
  endtask

  // mostly well-formed allocate/free traffic inside the current range,
  // with some edge and far-away frees and a few malformed requests
  task automatic random_items(input int total);
    int base;
    int span;
    int pick;
    int sel;
    logic [OP_W-1:0]   op;
    logic [REQ_W-1:0]  want;
    logic [PORT_W-1:0] port;
    for (int i = 0; i < total; i++) begin
      base = sb.range_base();
      span = sb.range_size();
      pick = $urandom_range(0, 99);
      want = ($urandom_range(0, 3) == 0) ? REQ_W'($urandom_range(1, MAX_REQUEST_DEF))
                                         : REQ_W'($urandom_range(1, 4));
      port = PORT_W'($urandom_range(0, 65535));
      if (pick < 38) begin
        op = OP_SCATTER;
      end else if (pick < 62) begin
        op = OP_CONTIG;
      end else if (pick < 95) begin
        op  = OP_FREE;
        sel = $urandom_range(0, 9);
        // just below the range, first port past its end, or somewhere inside
        if (sel == 1) port = PORT_W'(base - 1);
        else if (sel == 2) port = PORT_W'(base + span);
        else if (sel > 2) port = PORT_W'(base + $urandom_range(0, span - 1));
      end else if ($urandom_range(0, 2) == 0) begin
        op = OP_UNUSED;
      end else begin
        // allocation with a count the block has to refuse
        op   = ($urandom_range(0, 1) == 0) ? OP_SCATTER : OP_CONTIG;
        want = ($urandom_range(0, 3) == 0) ? '0
                                           : REQ_W'($urandom_range(MAX_REQUEST_DEF + 1, 31));
      end
      send_request(op, want, port);
    end
  endtask

  initial begin
    sb               = new();
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = '0;
    cfg_wdata        = '0;
    in_valid         = 1'b0;
    in_operation     = '0;
    in_request_count = '0;
    in_port_number   = '0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // reset range 16000..16999
    send_request(OP_SCATTER, 5'd1,  16'd0);
    send_request(OP_SCATTER, 5'd16, 16'd0);
    send_request(OP_CONTIG,  5'd16, 16'd0);
    send_request(OP_CONTIG,  5'd1,  16'd0);
    send_request(OP_FREE,    5'd1,  16'd16000);  // first port of the range
    send_request(OP_FREE,    5'd1,  16'd16999);  // last port of the range
    send_request(OP_FREE,    5'd1,  16'd17000);  // one past the end
    send_request(OP_FREE,    5'd1,  16'd15999);
    send_request(OP_FREE,    5'd1,  16'd0);
    send_request(OP_FREE,    5'd1,  16'd65535);
    send_request(OP_UNUSED,  5'd5,  16'hAAAA);
    send_request(OP_SCATTER, 5'd0,  16'd0);
    send_request(OP_CONTIG,  5'd17, 16'd0);
    send_request(OP_SCATTER, 5'd31, 16'd0);
    send_request(OP_SCATTER, 5'd2,  16'd0);      // picks up the freed first port

    // five-port range: shortfall, empty range, fragmented contiguous miss
    program_range(16'd100, 11'd5);
    send_request(OP_SCATTER, 5'd3, 16'd0);
    send_request(OP_SCATTER, 5'd3, 16'd0);       // only two left, they stay taken
    send_request(OP_SCATTER, 5'd1, 16'd0);       // nothing free at all
    send_request(OP_CONTIG,  5'd1, 16'd0);
    send_request(OP_FREE,    5'd1, 16'd101);
    send_request(OP_FREE,    5'd1, 16'd103);
    send_request(OP_CONTIG,  5'd2, 16'd0);       // two free ports, not adjacent
    send_request(OP_FREE,    5'd1, 16'd104);
    send_request(OP_CONTIG,  5'd2, 16'd0);
    send_request(OP_FREE,    5'd1, 16'd105);

    // random traffic over a spread of range settings
    program_range(16'd0, 11'd1);
    random_items(20);
    program_range(16'd65530, 11'd1024);          // clipped by the top of the port space
    random_items(25);
    program_range(16'd65535, 11'd7);
    random_items(10);
    program_range(PORT_W'($urandom_range(0, 65535)), '0);   // count 0 selects the default
    random_items(30);
    program_range(PORT_W'($urandom_range(0, 64512)), 11'd2047);
    random_items(25);
    program_range(PORT_W'($urandom_range(0, 64512)), 11'd1024);
    random_items(20);
    for (int ph = 0; ph < 4; ph++) begin
      program_range(PORT_W'($urandom_range(0, 65535)), CNT_CFG_W'($urandom_range(8, 48)));
      if (ph == 1) steady_flow = 1'b1;
      if (ph == 2) hold_off_request = 1'b1;      // fill the block until it backs up
      random_items(44);
      steady_flow = 1'b0;
    end

    settle();
    if (sb.due_results.size() != 0)
      sb.report_mismatch($sformatf("%0d result items never arrived", sb.due_results.size()));
    $display("covered %0d requests over %0d range settings, %0d result items checked",
             sb.requests, settings + 1, sb.results);
    $display("scatter shortfalls %0d, contiguous misses %0d, in-range frees %0d",
             sb.shortfalls, sb.contig_misses, sb.frees_hit);
    if (sb.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // watchdog, well beyond the slowest legal run
  initial begin
    #(80_000_000);
    $display("watchdog expired, %0d result items outstanding", sb.due_results.size());
    $display("Test completed with failures");
    $finish;
  end
endmodule
